@@ rtl/rtv_pkg.sv @@
// Shared types and constants for the RGB to HSV converter.
// No dependencies; imported by rtv_div_stage, the top level and the bench result checker.
package rtv_pkg;

  // Hue arithmetic constants
  localparam logic [7:0] HUE_STEP   = 8'd43;
  localparam logic [7:0] BASE_RED   = 8'd0;
  localparam logic [7:0] BASE_GREEN = 8'd85;
  localparam logic [7:0] BASE_BLUE  = 8'd171;
  localparam logic [7:0] FULL_SCALE = 8'd255;

  // Divider geometry: 8 quotient bits, 16-bit partial remainder
  localparam int unsigned CHAN_W          = 8;
  localparam int unsigned QUO_W           = 8;
  localparam int unsigned QUO_IDX_W       = $clog2(QUO_W);
  localparam int unsigned REM_W           = 16;
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

  // Which channel holds the maximum
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // Item after the max/min stage
  typedef struct packed {
    logic [CHAN_W-1:0] brightness;
    logic [CHAN_W-1:0] span;
    logic [CHAN_W-1:0] diff_mag;
    logic              hue_neg;
    sector_t           sector;
  } front_item_t;

  // Item inside the division pipeline
  typedef struct packed {
    logic [REM_W-1:0]  sat_rem;
    logic [QUO_W-1:0]  sat_quo;
    logic [REM_W-1:0]  hue_rem;
    logic [QUO_W-1:0]  hue_quo;
    logic [CHAN_W-1:0] brightness;
    logic [CHAN_W-1:0] span;
    logic              hue_neg;
    sector_t           sector;
  } div_item_t;

endpackage

@@ rtl/rtv_div_stage.sv @@
// One register stage of the pipelined restoring divider.
// Resolves STEPS_PER_STAGE quotient bits of both the saturation and hue quotients.
// Depends on rtv_pkg.
module rtv_div_stage #(
  parameter int unsigned STAGE_IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  rtv_pkg::div_item_t up_item,
  output logic              up_ready,
  output logic              dn_valid,
  output rtv_pkg::div_item_t dn_item,
  input  logic              dn_ready
);
  import rtv_pkg::*;

  localparam int unsigned FIRST_SHIFT = QUO_W - 1 - STAGE_IDX * STEPS_PER_STAGE;

  logic      valid_r;
  div_item_t item_r;
  div_item_t item_nxt;
  logic [REM_W-1:0] sat_dsh;
  logic [REM_W-1:0] hue_dsh;

  // Compare and subtract the shifted divisor, one quotient bit per step
  always_comb begin
    item_nxt = up_item;
    sat_dsh  = '0;
    hue_dsh  = '0;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      sat_dsh = REM_W'(item_nxt.brightness) << (FIRST_SHIFT - s);
      hue_dsh = REM_W'(item_nxt.span) << (FIRST_SHIFT - s);
      if (item_nxt.sat_rem >= sat_dsh) begin
        item_nxt.sat_rem = item_nxt.sat_rem - sat_dsh;
        item_nxt.sat_quo[QUO_IDX_W'(FIRST_SHIFT - s)] = 1'b1;
      end
      if (item_nxt.hue_rem >= hue_dsh) begin
        item_nxt.hue_rem = item_nxt.hue_rem - hue_dsh;
        item_nxt.hue_quo[QUO_IDX_W'(FIRST_SHIFT - s)] = 1'b1;
      end
    end
  end

  // Advance when empty or when the next stage takes the held item
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

@@ rtl/rgb_to_hsv_converter_top.sv @@
// Top level of the 8-bit RGB to HSV converter.
// Depends on rtv_pkg and rtv_div_stage.
//
// Converts one 8-bit RGB pixel into 8-bit hue, saturation and brightness
// (value). The block accepts one item every clock while in_stall is low and
// passes each item through its stages in order: one stage finds max, min and
// sector, one stage forms the two dividends with constant multiplies, four
// stages run a restoring divider at two quotient bits per stage for saturation
// and hue in parallel, and one output register applies the sector base and the
// black and grey cases. Bubbles collapse, so an item is taken while a finished
// result waits as long as any stage is empty. Reset clears only the valid bits.
module rgb_to_hsv_converter_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_hue,
  output logic [7:0] out_saturation,
  output logic [7:0] out_brightness
);
  import rtv_pkg::*;

  // ---------------------------------------------------------------
  // Stage 1: max, min, sector and signed channel difference
  // ---------------------------------------------------------------
  logic        s1_valid_r;
  front_item_t s1_item_r;
  front_item_t s1_item_nxt;
  logic        s1_ready;
  logic [CHAN_W-1:0] mx;
  logic [CHAN_W-1:0] mn;
  logic [CHAN_W-1:0] diff_a;
  logic [CHAN_W-1:0] diff_b;

  always_comb begin
    mx = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx)  mx = in_blue;
    mn = in_red;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn)  mn = in_blue;

    // Ties resolve red over green over blue
    if (in_red >= in_green && in_red >= in_blue) begin
      s1_item_nxt.sector = SECT_RED;
      diff_a = in_green;
      diff_b = in_blue;
    end else if (in_green >= in_blue) begin
      s1_item_nxt.sector = SECT_GREEN;
      diff_a = in_blue;
      diff_b = in_red;
    end else begin
      s1_item_nxt.sector = SECT_BLUE;
      diff_a = in_red;
      diff_b = in_green;
    end

    s1_item_nxt.brightness = mx;
    s1_item_nxt.span       = mx - mn;
    s1_item_nxt.hue_neg    = diff_a < diff_b;
    s1_item_nxt.diff_mag   = (diff_a < diff_b) ? (diff_b - diff_a) : (diff_a - diff_b);
  end

  // ---------------------------------------------------------------
  // Stage 2: dividends 255 * span and 43 * |difference|
  // ---------------------------------------------------------------
  logic      s2_valid_r;
  div_item_t s2_item_r;
  div_item_t s2_item_nxt;
  logic      s2_ready;

  always_comb begin
    s2_item_nxt.sat_rem    = REM_W'(FULL_SCALE) * REM_W'(s1_item_r.span);
    s2_item_nxt.hue_rem    = REM_W'(HUE_STEP) * REM_W'(s1_item_r.diff_mag);
    s2_item_nxt.sat_quo    = '0;
    s2_item_nxt.hue_quo    = '0;
    s2_item_nxt.brightness = s1_item_r.brightness;
    s2_item_nxt.span       = s1_item_r.span;
    s2_item_nxt.hue_neg    = s1_item_r.hue_neg;
    s2_item_nxt.sector     = s1_item_r.sector;
  end

  // ---------------------------------------------------------------
  // Stages 3 to 6: restoring divider
  // ---------------------------------------------------------------
  logic      div_valid [DIV_STAGES+1];
  div_item_t div_item  [DIV_STAGES+1];
  logic      div_ready [DIV_STAGES+1];

  assign div_valid[0] = s2_valid_r;
  assign div_item[0]  = s2_item_r;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    rtv_div_stage #(
      .STAGE_IDX (k)
    ) u_div_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (div_valid[k]),
      .up_item  (div_item[k]),
      .up_ready (div_ready[k]),
      .dn_valid (div_valid[k+1]),
      .dn_item  (div_item[k+1]),
      .dn_ready (div_ready[k+1])
    );
  end

  // ---------------------------------------------------------------
  // Stage 7: sector base, sign and special cases into output register
  // ---------------------------------------------------------------
  logic        out_valid_r;
  logic [7:0]  hue_r;
  logic [7:0]  sat_r;
  logic [7:0]  bright_r;
  logic [7:0]  hue_nxt;
  logic [7:0]  sat_nxt;
  logic [7:0]  hue_base;
  logic [7:0]  hue_ofs;
  logic        out_ready;
  div_item_t   fin;

  assign fin = div_item[DIV_STAGES];

  always_comb begin
    case (fin.sector)
      SECT_RED:   hue_base = BASE_RED;
      SECT_GREEN: hue_base = BASE_GREEN;
      SECT_BLUE:  hue_base = BASE_BLUE;
      default:    hue_base = BASE_RED;
    endcase
    hue_ofs = fin.hue_neg ? (8'd0 - fin.hue_quo) : fin.hue_quo;
    // Black pixel: no saturation; grey pixel: no hue
    sat_nxt = (fin.brightness == '0) ? 8'd0 : fin.sat_quo;
    hue_nxt = (fin.span == '0) ? 8'd0 : (hue_base + hue_ofs);
  end

  // ---------------------------------------------------------------
  // Flow control: each stage advances when empty or drained
  // ---------------------------------------------------------------
  assign out_ready             = !out_valid_r || !out_stall;
  assign div_ready[DIV_STAGES] = out_ready;
  assign s2_ready              = !s2_valid_r || div_ready[0];
  assign s1_ready              = !s1_valid_r || s2_ready;
  assign in_stall              = !s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid_r  <= in_valid;
      if (s2_ready)  s2_valid_r  <= s1_valid_r;
      if (out_ready) out_valid_r <= div_valid[DIV_STAGES];
    end
  end

  // Hold payload unless a new item moves in
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_item_r <= s1_item_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      s2_item_r <= s2_item_nxt;
    end
    if (out_ready && div_valid[DIV_STAGES]) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= fin.brightness;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bright_r;

endmodule

@@ rtl/rtv_checker.sv @@
// Port-level assertions for the RGB to HSV converter.
// Depends on rgb_to_hsv_converter_top; attached by the bind at the end of this file.
module rtv_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_hue,
  input logic [7:0] out_saturation,
  input logic [7:0] out_brightness
);

  // A stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hue)
      && $stable(out_saturation) && $stable(out_brightness))
    else $error("stalled result item changed");

  // Input backs up only when the whole pipeline is full and the output is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the pipeline has room");

  // Black pixel carries no hue and no saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_brightness == 8'd0 |-> out_hue == 8'd0 && out_saturation == 8'd0)
    else $error("black pixel with nonzero hue or saturation");

  // Grey pixel carries no hue
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturation == 8'd0 |-> out_hue == 8'd0)
    else $error("grey pixel with nonzero hue");

  // Saturation never exceeds what value allows to be nonzero
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturation != 8'd0 |-> out_brightness != 8'd0)
    else $error("saturation without brightness");

endmodule

bind rgb_to_hsv_converter_top rtv_checker u_rtv_checker (.*);

@@ bench/hsv_pixel_checker.sv @@
// Result checker for the RGB to HSV converter: predicts each pixel's HSV and
// compares it with the converter's output stream. Depends on rtv_pkg.
module hsv_pixel_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_hue,
  input  logic [7:0]  out_saturation,
  input  logic [7:0]  out_brightness,
  output int unsigned fail_count,
  output int unsigned results_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rtv_pkg::*;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  // Pixel kept beside its prediction so a mismatch can name its input
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    hsv_t       hsv;
  } pixel_hsv_t;

  pixel_hsv_t  expected_hsv[$];
  int unsigned failures = 0;
  int unsigned results_seen = 0;

  // Predict hue, saturation and value of one pixel
  function automatic hsv_t hsv_of_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    hsv_t        px;
    logic [7:0]  vmax;
    logic [7:0]  vmin;
    logic [7:0]  base;
    logic [7:0]  lead;
    logic [7:0]  trail;
    logic [7:0]  mag;
    logic [7:0]  offset;
    int unsigned span;
    int unsigned sat;
    sector_t     sect;
    vmax = r;
    if (g > vmax) vmax = g;
    if (b > vmax) vmax = b;
    vmin = r;
    if (g < vmin) vmin = g;
    if (b < vmin) vmin = b;
    px.brightness = vmax;
    px.saturation = 8'd0;
    px.hue        = 8'd0;
    // black pixel: hue and saturation stay zero
    if (vmax == 8'd0) return px;
    span = 32'(vmax - vmin);
    sat  = (FULL_SCALE * span) / vmax;
    px.saturation = sat[7:0];
    // grey pixel: hue stays zero
    if (sat == 0) return px;
    // tied maximum resolves red, then green, then blue
    if (vmax == r) sect = SECT_RED;
    else if (vmax == g) sect = SECT_GREEN;
    else sect = SECT_BLUE;
    case (sect)
      SECT_RED: begin
        base = BASE_RED;   lead = g; trail = b;
      end
      SECT_GREEN: begin
        base = BASE_GREEN; lead = b; trail = r;
      end
      default: begin
        base = BASE_BLUE;  lead = r; trail = g;
      end
    endcase
    // offset truncates toward zero, then the sum wraps modulo 256
    if (lead >= trail) begin
      mag    = 8'((HUE_STEP * (lead - trail)) / span);
      offset = mag;
    end else begin
      mag    = 8'((HUE_STEP * (trail - lead)) / span);
      offset = 8'd0 - mag;
    end
    px.hue = base + offset;
    return px;
  endfunction

  // Compare each output item with the oldest prediction, then log new input items
  always @(posedge clk) begin
    pixel_hsv_t head;
    pixel_hsv_t fresh;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_hsv.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("ERROR: %0t result %0d with nothing expected: h=%0d s=%0d v=%0d",
                     $realtime, results_seen, out_hue, out_saturation, out_brightness);
        end else begin
          head = expected_hsv.pop_front();
          if (out_hue !== head.hsv.hue || out_saturation !== head.hsv.saturation ||
              out_brightness !== head.hsv.brightness) begin
            failures++;
            if (failures <= 10)
              $display({"ERROR: %0t result %0d for rgb=(%0d,%0d,%0d): ",
                        "expected h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d"},
                       $realtime, results_seen, head.red, head.green, head.blue,
                       head.hsv.hue, head.hsv.saturation, head.hsv.brightness,
                       out_hue, out_saturation, out_brightness);
          end
        end
      end
      if (in_valid && !in_stall) begin
        fresh.red   = in_red;
        fresh.green = in_green;
        fresh.blue  = in_blue;
        fresh.hsv   = hsv_of_pixel(in_red, in_green, in_blue);
        expected_hsv.push_back(fresh);
      end
    end
    fail_count      <= failures;
    results_pending <= expected_hsv.size();
  end

endmodule

@@ bench/tb_rgb_to_hsv_converter_top.sv @@
// Testbench top for the RGB to HSV converter: drives pixels and output stalls,
// gives the verdict. Depends on rgb_to_hsv_converter_top and hsv_pixel_checker.
module tb_rgb_to_hsv_converter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_PIXELS = 640;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_hue;
  logic [7:0]  out_saturation;
  logic [7:0]  out_brightness;
  int unsigned fail_count;
  int unsigned results_pending;
  bit          send_burst = 1'b0;
  bit          take_burst = 1'b0;

  rgb_to_hsv_converter_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  hsv_pixel_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hue         (out_hue),
    .out_saturation  (out_saturation),
    .out_brightness  (out_brightness),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Offer one item after a random gap, hold it until accepted
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  // Output side: stall a random number of cycles before each item
  initial begin
    int unsigned hold;
    out_stall <= 1'b1;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
      hold = take_burst ? 0 : $urandom_range(0, 15);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Stimulus and verdict
  initial begin
    logic [23:0] corner_pixels[] = '{
      24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
      24'h808080, 24'h010101, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
      24'hFF0080, 24'h00FF80, 24'h8000FF, 24'hFF0001, 24'h010000,
      24'h000100, 24'h000001, 24'hFEFFFE, 24'h55AA00, 24'hAA5500,
      24'h0055AA
    };
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  peak;
    int unsigned kind;
    int unsigned pair;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_red   <= 8'd0;
    in_green <= 8'd0;
    in_blue  <= 8'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, each sector, ties, black, grey and negative hue
    foreach (corner_pixels[i])
      send_pixel(corner_pixels[i][23:16], corner_pixels[i][15:8], corner_pixels[i][7:0]);

    // Random: plain pixels mixed with greys, ties, tiny values, 0/255 corners and near-greys
    repeat (RANDOM_PIXELS) begin
      r    = 8'($urandom_range(0, 255));
      g    = 8'($urandom_range(0, 255));
      b    = 8'($urandom_range(0, 255));
      kind = $urandom_range(0, 9);
      case (kind)
        5: begin
          g = r;
          b = r;
        end
        6: begin
          peak = r;
          pair = $urandom_range(0, 2);
          if (pair == 0) begin
            g = peak; b = 8'($urandom_range(0, peak));
          end else if (pair == 1) begin
            b = peak; g = 8'($urandom_range(0, peak));
          end else begin
            g = peak; b = peak; r = 8'($urandom_range(0, peak));
          end
        end
        7: begin
          r = 8'($urandom_range(0, 3));
          g = 8'($urandom_range(0, 3));
          b = 8'($urandom_range(0, 3));
        end
        8: begin
          r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        9: begin
          g = (r > 8'd3) ? r - 8'($urandom_range(0, 3)) : r;
          b = (r > 8'd3) ? r - 8'($urandom_range(0, 3)) : r;
        end
        default: begin
        end
      endcase
      send_pixel(r, g, b);
    end
    in_valid <= 1'b0;

    // Drain the pipeline, then watch for stray items before the verdict
    do @(posedge clk); while (results_pending != 0);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rtv_pkg.sv
rtl/rtv_div_stage.sv
rtl/rgb_to_hsv_converter_top.sv
rtl/rtv_checker.sv
bench/hsv_pixel_checker.sv
bench/tb_rgb_to_hsv_converter_top.sv
